[rtl/quoted_token_splitter_top_macros.svh]
// assertion macros for the quoted token splitter
`ifndef QUOTED_TOKEN_SPLITTER_TOP_MACROS_SVH
`define QUOTED_TOKEN_SPLITTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define QTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/qts_pkg.sv]
// types and constants shared by the quoted token splitter files
package qts_pkg;

   localparam int unsigned LINE_W = 20;
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);

   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_LF        = 8'h0a;
   localparam logic [7:0] CH_CR        = 8'h0d;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_BARE    = 3'd2,
      MODE_QUOTED  = 3'd3,
      MODE_ESCAPE  = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [7:0]        held_char;
      logic              held_valid;
      logic [LINE_W-1:0] held_line;
      logic [LINE_W-1:0] line_counter;
      logic              after_cr;
   } parse_state_type;

   typedef struct packed {
      logic              valid;
      logic [7:0]        token_char;
      logic              last_in_token;
      logic [LINE_W-1:0] line_number;
   } token_out_type;

endpackage

[rtl/qts_step.sv]
// next-state and result logic for one text byte of the token splitter
module qts_step (
   input  logic [7:0]               text_byte,
   input  logic                     end_of_text,
   input  qts_pkg::parse_state_type cur,
   output qts_pkg::parse_state_type nxt,
   output qts_pkg::token_out_type   res
);

   logic       eol;
   logic       do_add;
   logic       do_end;
   logic [7:0] add_ch;

   always_comb begin
      nxt    = cur;
      res    = '0;
      eol    = (text_byte == qts_pkg::CH_LF) || (text_byte == qts_pkg::CH_CR);
      do_add = 1'b0;
      do_end = 1'b0;
      add_ch = text_byte;

      if (end_of_text) begin
         do_end       = 1'b1;
         nxt.mode     = qts_pkg::MODE_BETWEEN;
         nxt.after_cr = 1'b0;
      end else if ((text_byte == qts_pkg::CH_LF) && cur.after_cr) begin
         // lf of a cr-lf pair: already counted
         nxt.after_cr = 1'b0;
      end else begin
         nxt.after_cr = (text_byte == qts_pkg::CH_CR);
         unique case (cur.mode)
            qts_pkg::MODE_COMMENT: begin
               if (eol) nxt.mode = qts_pkg::MODE_BETWEEN;
            end
            qts_pkg::MODE_BARE: begin
               if (eol || (text_byte == qts_pkg::CH_SPACE)) begin
                  do_end   = 1'b1;
                  nxt.mode = qts_pkg::MODE_BETWEEN;
               end else begin
                  do_add = 1'b1;
               end
            end
            qts_pkg::MODE_QUOTED: begin
               if (text_byte == qts_pkg::CH_BACKSLASH) begin
                  nxt.mode = qts_pkg::MODE_ESCAPE;
               end else if (text_byte == qts_pkg::CH_QUOTE) begin
                  do_end   = 1'b1;
                  nxt.mode = qts_pkg::MODE_BETWEEN;
               end else if (!eol) begin
                  do_add = 1'b1;
               end
            end
            qts_pkg::MODE_ESCAPE: begin
               nxt.mode = qts_pkg::MODE_QUOTED;
               do_add   = !eol;
               if (text_byte == qts_pkg::CH_N) add_ch = qts_pkg::CH_LF;
            end
            default: begin
               nxt.mode = qts_pkg::MODE_BETWEEN;
               if (!eol && (text_byte != qts_pkg::CH_SPACE)) begin
                  if (text_byte == qts_pkg::CH_HASH) begin
                     nxt.mode = qts_pkg::MODE_COMMENT;
                  end else if (text_byte == qts_pkg::CH_QUOTE) begin
                     nxt.mode = qts_pkg::MODE_QUOTED;
                  end else begin
                     nxt.mode = qts_pkg::MODE_BARE;
                     do_add   = 1'b1;
                  end
               end
            end
         endcase
         if (eol && (cur.line_counter != qts_pkg::LINE_MAX)) begin
            nxt.line_counter = cur.line_counter + qts_pkg::LINE_W'(1);
         end
      end

      // emit the held character, marked when the token closes
      if ((do_end || do_add) && cur.held_valid) begin
         res.valid         = 1'b1;
         res.token_char    = cur.held_char;
         res.last_in_token = do_end;
         res.line_number   = cur.held_line;
      end
      if (do_end) nxt.held_valid = 1'b0;
      if (do_add) begin
         nxt.held_char  = add_ch;
         nxt.held_line  = cur.line_counter;
         nxt.held_valid = 1'b1;
      end
   end

endmodule

[rtl/quoted_token_splitter_top.sv]
// top level of the quoted token splitter
// Splits a byte stream into tokens and returns their characters one per
// item, each with the line it was read on and a mark on the last character
// of its token. Bare words end at a space or line end, '#' at a token start
// skips the rest of the line, double quotes enclose tokens that may hold
// spaces and span lines, and inside quotes a backslash turns 'n' into a
// newline and passes any other byte but a line end. A character leaves one
// input item late, since only the next byte tells whether it ends its
// token; an item with end_of_text set flushes it. The block takes one byte
// per cycle while the rsp side keeps up: an item is captured in the input
// register, parsed by one step of the parse state machine once the result
// register can take it, and written to the result register. Each item
// yields zero or one result; both registers advance together whenever the
// result register is empty or being drained, so a stalled rsp side backs
// up into req_ready only once both stages are full.
module quoted_token_splitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_token_char,
   output logic        rsp_last_in_token,
   output logic [19:0] rsp_line_number
);

`include "quoted_token_splitter_top_macros.svh"

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // parse state and result register
   qts_pkg::parse_state_type state_ff;
   qts_pkg::parse_state_type state_in;
   qts_pkg::parse_state_type step_state;
   qts_pkg::token_out_type   step_res;
   qts_pkg::token_out_type   out_ff;
   qts_pkg::token_out_type   out_in;

   logic advance;

   // the parse step fires when a byte waits and the result slot can take it
   assign advance   = in_valid_ff && (!out_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   qts_step u_step (
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .cur         (state_ff),
      .nxt         (step_state),
      .res         (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      state_in    = state_ff;
      out_in      = out_ff;
      if (out_ff.valid && rsp_ready) out_in.valid = 1'b0;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
         // an item without a result leaves the slot as drained above
         if (step_res.valid) out_in = step_res;
      end
      if (req_valid && req_ready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_ff.valid          <= 1'b0;
         state_ff.mode         <= qts_pkg::MODE_BETWEEN;
         state_ff.held_char    <= 8'h00;
         state_ff.held_valid   <= 1'b0;
         state_ff.held_line    <= qts_pkg::LINE_FIRST;
         state_ff.line_counter <= qts_pkg::LINE_FIRST;
         state_ff.after_cr     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_ff.valid <= out_in.valid;
         state_ff     <= state_in;
      end
      // result payload, no reset needed
      out_ff.token_char    <= out_in.token_char;
      out_ff.last_in_token <= out_in.last_in_token;
      out_ff.line_number   <= out_in.line_number;
   end

   // input payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   assign rsp_valid         = out_ff.valid;
   assign rsp_token_char    = out_ff.token_char;
   assign rsp_last_in_token = out_ff.last_in_token;
   assign rsp_line_number   = out_ff.line_number;

   // a closing mark always leaves no held character behind
   `QTS_ASSERT_NEXT(a_last_clears_held, clock, reset, advance && step_res.valid && step_res.last_in_token, !state_ff.held_valid, "held character survived token end")
   // a held character only exists inside a token
   `QTS_ASSERT_NOW(a_held_in_token, clock, reset, state_ff.held_valid, (state_ff.mode == qts_pkg::MODE_BARE) || (state_ff.mode == qts_pkg::MODE_QUOTED) || (state_ff.mode == qts_pkg::MODE_ESCAPE), "held character outside a token")
   // line numbers start at one and never wrap to zero
   `QTS_ASSERT_NOW(a_line_nonzero, clock, reset, 1'b1, state_ff.line_counter != '0, "line counter reached zero")
   // a waiting byte is kept until the parse step consumes it
   `QTS_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff) && $stable(in_eot_ff), "input register lost a byte")

endmodule

[tb/sv/quoted_token_splitter_checker.sv]
// checker for the quoted token splitter: predicts each result item and compares it
`timescale 1ns / 100ps

module quoted_token_splitter_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_text_byte,
   input  logic                       req_end_of_text,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [7:0]                 rsp_token_char,
   input  logic                       rsp_last_in_token,
   input  logic [qts_pkg::LINE_W-1:0] rsp_line_number,
   output int unsigned                mismatches,
   output int unsigned                pending
);

   typedef struct packed {
      logic [7:0]                 token_char;
      logic                       last_in_token;
      logic [qts_pkg::LINE_W-1:0] line_number;
   } token_rec_type;

   // predicted parser state
   qts_pkg::mode_type          mode;
   logic [7:0]                 pend_char;
   logic                       pend_ok;
   logic [qts_pkg::LINE_W-1:0] pend_line;
   logic [qts_pkg::LINE_W-1:0] cur_line;
   logic                       saw_cr;

   token_rec_type expected_tokens[$];
   token_rec_type want;
   token_rec_type next_tok;

   // hold a new character, release the one held before it
   function automatic logic append_char(input logic [7:0] c, output token_rec_type tok);
      logic emit;
      emit = pend_ok;
      tok.token_char = pend_char;
      tok.last_in_token = 1'b0;
      tok.line_number = pend_line;
      pend_char = c;
      pend_line = cur_line;
      pend_ok = 1'b1;
      return emit;
   endfunction

   // release the held character as the end of its token
   function automatic logic finish_token(output token_rec_type tok);
      logic emit;
      emit = pend_ok;
      tok.token_char = pend_char;
      tok.last_in_token = 1'b1;
      tok.line_number = pend_line;
      pend_ok = 1'b0;
      return emit;
   endfunction

   // one parser step; returns 1 when the byte releases a token character
   function automatic logic parse_byte(input logic [7:0] c, input logic eot,
                                       output token_rec_type tok);
      logic eol;
      logic emit;
      emit = 1'b0;
      tok = '0;
      eol = (c == qts_pkg::CH_LF) || (c == qts_pkg::CH_CR);
      if (eot) begin
         emit = finish_token(tok);
         mode = qts_pkg::MODE_BETWEEN;
         saw_cr = 1'b0;
      end else if (c == qts_pkg::CH_LF && saw_cr) begin
         saw_cr = 1'b0;
      end else begin
         saw_cr = (c == qts_pkg::CH_CR);
         case (mode)
            qts_pkg::MODE_COMMENT: begin
               if (eol) mode = qts_pkg::MODE_BETWEEN;
            end
            qts_pkg::MODE_BARE: begin
               if (eol || c == qts_pkg::CH_SPACE) begin
                  emit = finish_token(tok);
                  mode = qts_pkg::MODE_BETWEEN;
               end else begin
                  emit = append_char(c, tok);
               end
            end
            qts_pkg::MODE_QUOTED: begin
               if (c == qts_pkg::CH_BACKSLASH) begin
                  mode = qts_pkg::MODE_ESCAPE;
               end else if (c == qts_pkg::CH_QUOTE) begin
                  emit = finish_token(tok);
                  mode = qts_pkg::MODE_BETWEEN;
               end else if (!eol) begin
                  emit = append_char(c, tok);
               end
            end
            qts_pkg::MODE_ESCAPE: begin
               mode = qts_pkg::MODE_QUOTED;
               if (!eol) emit = append_char((c == qts_pkg::CH_N) ? qts_pkg::CH_LF : c, tok);
            end
            default: begin
               mode = qts_pkg::MODE_BETWEEN;
               if (!eol && c != qts_pkg::CH_SPACE) begin
                  if (c == qts_pkg::CH_HASH) begin
                     mode = qts_pkg::MODE_COMMENT;
                  end else if (c == qts_pkg::CH_QUOTE) begin
                     mode = qts_pkg::MODE_QUOTED;
                  end else begin
                     mode = qts_pkg::MODE_BARE;
                     emit = append_char(c, tok);
                  end
               end
            end
         endcase
         if (eol && cur_line != qts_pkg::LINE_MAX)
            cur_line = cur_line + qts_pkg::LINE_W'(1);
      end
      return emit;
   endfunction

   task automatic check_field(input string what, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s expected %h actual %h", $time, what, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode = qts_pkg::MODE_BETWEEN;
         pend_char = 8'h00;
         pend_ok = 1'b0;
         pend_line = qts_pkg::LINE_FIRST;
         cur_line = qts_pkg::LINE_FIRST;
         saw_cr = 1'b0;
         expected_tokens.delete();
      end else begin
         // results first: nothing accepted on this edge can leave on it
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: expected no item, actual char %h last %b line %h", $time,
                        rsp_token_char, rsp_last_in_token, rsp_line_number);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_char", want.token_char, rsp_token_char);
               check_field("last_in_token", want.last_in_token, rsp_last_in_token);
               check_field("line_number", want.line_number, rsp_line_number);
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_text_byte, req_end_of_text, next_tok))
               expected_tokens.push_back(next_tok);
         end
      end
      pending = expected_tokens.size();
   end

endmodule

[tb/sv/quoted_token_splitter_top_test.sv]
// testbench top for the quoted token splitter: stimulus, pacing and verdict
`timescale 1ns / 100ps

module quoted_token_splitter_top_test;

   localparam int unsigned CYCLE_LIMIT  = 100_000;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned DRAIN_CYCLES = 6;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_HALF,
      PACE_SPARSE,
      PACE_TOGGLE
   } pace_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_text_byte;
   logic                       req_end_of_text;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [7:0]                 rsp_token_char;
   logic                       rsp_last_in_token;
   logic [qts_pkg::LINE_W-1:0] rsp_line_number;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned hold_requests;

   quoted_token_splitter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_char    (rsp_token_char),
      .rsp_last_in_token (rsp_last_in_token),
      .rsp_line_number   (rsp_line_number)
   );

   quoted_token_splitter_checker token_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_char    (rsp_token_char),
      .rsp_last_in_token (rsp_last_in_token),
      .rsp_line_number   (rsp_line_number),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver pacing: stretches of one style, plus a long hold-off on request
   initial begin : rsp_pacing
      int unsigned stretch_left;
      int unsigned hold_left;
      int unsigned holds_seen;
      pace_type    pace;
      stretch_left = 0;
      hold_left = 0;
      holds_seen = 0;
      pace = PACE_FULL;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (stretch_left == 0) begin
            pace = pace_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(10, 120);
         end
         stretch_left--;
         if (hold_left != 0) begin
            // long stall so both pipeline stages fill and req_ready drops
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (pace)
               PACE_FULL:   rsp_ready <= 1'b1;
               PACE_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               PACE_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // present one item at a falling edge and hold it until it is taken;
   // returns at the falling edge after acceptance
   task automatic offer(input logic [7:0] c, input logic eot);
      int unsigned gap;
      if (burst_left == 0) begin
         // end of a burst: drop valid for a random gap
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 60);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (burst_left != 0) burst_left--;
   endtask

   // stop offering until every predicted item has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
   endtask

   // printable, and never a quote, hash or backslash
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      if (c == qts_pkg::CH_QUOTE || c == qts_pkg::CH_HASH || c == qts_pkg::CH_BACKSLASH)
         c = 8'h78;
      return c;
   endfunction

   // any byte that does not end a bare word
   function automatic logic [7:0] body_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == qts_pkg::CH_SPACE || c == qts_pkg::CH_LF || c == qts_pkg::CH_CR);
      return c;
   endfunction

   task automatic send_line_end();
      case ($urandom_range(0, 2))
         0: offer(qts_pkg::CH_LF, 1'b0);
         1: offer(qts_pkg::CH_CR, 1'b0);
         default: begin
            offer(qts_pkg::CH_CR, 1'b0);
            offer(qts_pkg::CH_LF, 1'b0);
         end
      endcase
   endtask

   task automatic send_bare_word();
      int unsigned len;
      len = $urandom_range(1, 8);
      offer(plain_char(), 1'b0);
      repeat (len - 1) offer(($urandom_range(0, 4) == 0) ? body_byte() : plain_char(), 1'b0);
   endtask

   task automatic send_quoted();
      int unsigned len;
      int unsigned pick;
      len = $urandom_range(0, 10);
      offer(qts_pkg::CH_QUOTE, 1'b0);
      repeat (len) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            offer(plain_char(), 1'b0);
         end else if (pick == 5) begin
            offer(qts_pkg::CH_SPACE, 1'b0);
         end else if (pick == 6) begin
            // escape: n, quote, backslash, line end or anything else
            offer(qts_pkg::CH_BACKSLASH, 1'b0);
            case ($urandom_range(0, 5))
               0: offer(qts_pkg::CH_N, 1'b0);
               1: offer(qts_pkg::CH_QUOTE, 1'b0);
               2: offer(qts_pkg::CH_BACKSLASH, 1'b0);
               3: offer(qts_pkg::CH_LF, 1'b0);
               4: offer(qts_pkg::CH_CR, 1'b0);
               default: offer(8'($urandom_range(0, 255)), 1'b0);
            endcase
         end else if (pick == 7) begin
            send_line_end();
         end else begin
            offer(body_byte(), 1'b0);
         end
      end
      // now and then the quote is left open
      if ($urandom_range(0, 15) != 0) offer(qts_pkg::CH_QUOTE, 1'b0);
   endtask

   // mostly well-formed text with random content, the rest noise
   task automatic run_random(input int unsigned target);
      int unsigned pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_bare_word();
         end else if (pick < 58) begin
            send_quoted();
         end else if (pick < 66) begin
            // comment to the end of the line
            offer(qts_pkg::CH_HASH, 1'b0);
            repeat ($urandom_range(0, 8)) offer(body_byte(), 1'b0);
            send_line_end();
         end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 0)
               repeat ($urandom_range(1, 2)) offer(qts_pkg::CH_SPACE, 1'b0);
            else send_line_end();
         end else if (pick < 93) begin
            // end of text, byte ignored
            offer(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) offer(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_text_byte = 8'h00;
      req_end_of_text = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      items_sent = 0;
      burst_left = 0;
      hold_requests = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: quote and hash are ordinary inside a bare word
      send_text("a\"# ");
      // comment closed by a cr lf pair
      send_text("#c");
      offer(qts_pkg::CH_CR, 1'b0);
      offer(qts_pkg::CH_LF, 1'b0);
      // quoted: space, dropped line break, \n escape, backslash before line end,
      // escaped quote, then a bare word right after the closing quote
      send_text("\"x ");
      offer(qts_pkg::CH_LF, 1'b0);
      send_text("\\n\\");
      offer(qts_pkg::CH_LF, 1'b0);
      send_text("\\\"\"z");
      // byte zero and all ones inside a word, flushed by end of text
      offer(8'h00, 1'b0);
      offer(8'hff, 1'b0);
      offer(8'h5a, 1'b1);
      // empty quotes give nothing, then a lone cr
      send_text("\"\"");
      offer(qts_pkg::CH_CR, 1'b0);
      // end of text inside an open quote and inside a comment
      send_text("\"q");
      offer(qts_pkg::CH_HASH, 1'b1);
      send_text("#k");
      offer(8'hff, 1'b1);

      run_random(300);
      // receiver holds off while the sender keeps offering
      hold_requests++;
      run_random(700);
      wait_drained();
      run_random(1250);
      offer(8'h00, 1'b1);

      wait_drained();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/qts_pkg.sv
rtl/qts_step.sv
rtl/quoted_token_splitter_top.sv
tb/sv/quoted_token_splitter_checker.sv
tb/sv/quoted_token_splitter_top_test.sv
